// File: src/tcce_pkg.sv
// Shared constants, types and lookup tables for the text console character engine.
// Used by tcce_cursor, text_console_character_engine, tcce_checker and the testbench; depends on nothing.
package tcce_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 24;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = COLUMNS * ROWS;

    localparam int CELL_W    = $clog2(CELLS);
    localparam int ROW_W     = $clog2(ROWS + 2);
    localparam int ROW_IDX_W = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int PH_W      = $clog2(TAB_WIDTH) + 1;

    // Port widths fixed by the interface
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_DW = ATTR_W + CHAR_W;
    localparam int ADDR_W  = 11;

    localparam logic [ATTR_W-1:0]  RESET_ATTR  = 8'h07;
    localparam logic [CELL_DW-1:0] RESET_BLANK = {RESET_ATTR, 8'h00};

    // Operation codes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_SCROLL,
        ST_FLUSH
    } state_t;

    // Tab phase tables: (row start) mod TAB_WIDTH and column mod TAB_WIDTH
    typedef logic [PH_W-1:0] phase_t;
    typedef phase_t row_phase_tab_t [ROWS];
    typedef phase_t col_phase_tab_t [COLUMNS];

    function automatic row_phase_tab_t calc_row_phase();
        row_phase_tab_t tab;
        for (int r = 0; r < ROWS; r++) begin
            tab[r] = PH_W'((r * COLUMNS) % TAB_WIDTH);
        end
        return tab;
    endfunction

    function automatic col_phase_tab_t calc_col_phase();
        col_phase_tab_t tab;
        for (int c = 0; c < COLUMNS; c++) begin
            tab[c] = PH_W'(c % TAB_WIDTH);
        end
        return tab;
    endfunction

    localparam row_phase_tab_t ROW_PHASE = calc_row_phase();
    localparam col_phase_tab_t COL_PHASE = calc_col_phase();

    // Sequencer to cursor unit
    typedef struct packed {
        logic              move;
        logic [CHAR_W-1:0] code;
        logic              scroll;
    } cur_cmd_t;

    // Cursor unit to sequencer
    typedef struct packed {
        logic [CELL_W-1:0] pos;
        logic              over;
    } cur_stat_t;

endpackage

// File: src/text_console_character_engine.sv
// Put or read: the accepted item passes through ST_READ or ST_CHECK before the done strobe
//   (registered result). A new item is taken only in ST_IDLE; a put that scrolls also runs
//   the copy sweep through the screen RAM's single write port, then ST_FLUSH.
// Reset: cursor 0, attribute 7; a clearing pass over all CELLS (1920) cells then blanks the
//   screen RAM, with busy high. Results cannot be stalled by the receiver.
// Depends on tcce_pkg, tcce_ram and tcce_cursor.
module text_console_character_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [7:0]  char_code,
    input  logic [10:0] read_address,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output logic        done,
    output logic [15:0] read_data,
    output logic [10:0] cursor_position,
    output logic        scrolled
);

    localparam int CW = tcce_pkg::CELL_W;
    localparam int DW = tcce_pkg::CELL_DW;

    tcce_pkg::state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic          pend_blank_reg, pend_blank_next;
    logic [CW-1:0] pend_addr_reg, pend_addr_next;
    logic          addr_ok_reg;
    logic [tcce_pkg::ATTR_W-1:0] attr_reg;

    logic          done_reg, done_next;
    logic [DW-1:0] read_data_reg, read_data_next;
    logic [10:0]   cursor_position_reg, cursor_position_next;
    logic          scrolled_reg, scrolled_next;

    logic          mem_we, mem_re;
    logic [CW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    tcce_pkg::cur_cmd_t  cur_cmd;
    tcce_pkg::cur_stat_t cur_stat;

    logic accept;
    logic cnt_last;
    logic printable;

    assign accept   = start && (state_reg == tcce_pkg::ST_IDLE);
    assign cnt_last = (cnt_reg == CW'(tcce_pkg::CELLS - 1));
    assign printable = (char_code != tcce_pkg::CH_NUL) && (char_code != tcce_pkg::CH_BS)
                    && (char_code != tcce_pkg::CH_TAB) && (char_code != tcce_pkg::CH_LF)
                    && (char_code != tcce_pkg::CH_CR);

    tcce_ram #(
        .WIDTH (DW),
        .DEPTH (tcce_pkg::CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcce_cursor u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cur_cmd),
        .stat  (cur_stat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcce_pkg::ST_CLEAR:
            begin
                if (cnt_last)
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (opcode == tcce_pkg::OP_READ) ? tcce_pkg::ST_READ
                                                               : tcce_pkg::ST_CHECK;
                end
            end
            tcce_pkg::ST_READ:
            begin
                state_next = tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_CHECK:
            begin
                state_next = cur_stat.over ? tcce_pkg::ST_SCROLL : tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_SCROLL:
            begin
                if (cnt_last)
                begin
                    state_next = tcce_pkg::ST_FLUSH;
                end
            end
            tcce_pkg::ST_FLUSH:
            begin
                state_next = tcce_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcce_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control, RAM ports and result
    always_comb
    begin
        mem_we    = pend_reg;
        mem_waddr = pend_addr_reg;
        mem_wdata = pend_blank_reg ? {attr_reg, 8'h00} : mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = '0;
        cur_cmd   = '0;
        cnt_next        = cnt_reg;
        pend_next       = 1'b0;
        pend_blank_next = 1'b0;
        pend_addr_next  = cnt_reg;
        done_next            = 1'b0;
        read_data_next       = '0;
        cursor_position_next = 11'(cur_stat.pos);
        scrolled_next        = 1'b0;
        unique case (state_reg)
            tcce_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = tcce_pkg::RESET_BLANK;
                cnt_next  = cnt_last ? '0 : cnt_reg + CW'(1);
            end
            tcce_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == tcce_pkg::OP_READ)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = CW'(read_address);
                    end
                    else
                    begin
                        cur_cmd.move = 1'b1;
                        cur_cmd.code = char_code;
                        if (printable)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_stat.pos;
                            mem_wdata = {attr_reg, char_code};
                        end
                    end
                end
            end
            tcce_pkg::ST_READ:
            begin
                done_next      = 1'b1;
                read_data_next = addr_ok_reg ? mem_rdata : '0;
            end
            tcce_pkg::ST_CHECK:
            begin
                if (cur_stat.over)
                begin
                    cur_cmd.scroll = 1'b1;
                    cnt_next       = '0;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            tcce_pkg::ST_SCROLL:
            begin
                // Copy row r+1 to row r; blank the last row. Writes trail reads through the pend registers.
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                if (cnt_reg < CW'(tcce_pkg::CELLS - tcce_pkg::COLUMNS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cnt_reg + CW'(tcce_pkg::COLUMNS);
                end
                else
                begin
                    pend_blank_next = 1'b1;
                end
                cnt_next = cnt_last ? '0 : cnt_reg + CW'(1);
            end
            tcce_pkg::ST_FLUSH:
            begin
                done_next     = 1'b1;
                scrolled_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcce_pkg::ST_CLEAR;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            attr_reg       <= tcce_pkg::RESET_ATTR;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_blank_reg      <= pend_blank_next;
        pend_addr_reg       <= pend_addr_next;
        read_data_reg       <= read_data_next;
        cursor_position_reg <= cursor_position_next;
        scrolled_reg        <= scrolled_next;
        if (accept)
        begin
            addr_ok_reg <= (32'(read_address) < tcce_pkg::CELLS);
        end
    end

    assign busy            = (state_reg != tcce_pkg::ST_IDLE);
    assign done            = done_reg;
    assign read_data       = read_data_reg;
    assign cursor_position = cursor_position_reg;
    assign scrolled        = scrolled_reg && done_reg;

`ifndef SYNTH
    // A result only follows a state that completes an item
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == tcce_pkg::ST_READ
                   || $past(state_reg) == tcce_pkg::ST_CHECK
                   || $past(state_reg) == tcce_pkg::ST_FLUSH))
        else $error("result strobe without a completing state");

    // The scroll sweep has drained all trailing writes before idle
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcce_pkg::ST_IDLE) |-> !pend_reg)
        else $error("pending scroll write while idle");

    // Reported cursor is always on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (32'(cursor_position) < tcce_pkg::CELLS))
        else $error("cursor position off screen");

    // The cursor is never past the last row when an item is accepted
    a_cursor_valid_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !cur_stat.over)
        else $error("cursor past last row at accept");
`endif

endmodule

// File: src/tcce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1920,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port, registered read data, updated only when re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tcce_cursor.sv
// Cursor unit: row/column registers, control-character moves and scroll adjust.
// Depends on tcce_pkg for geometry, character codes and tab phase tables.
module tcce_cursor (
    input  logic               clk,
    input  logic               rst_n,
    input  tcce_pkg::cur_cmd_t cmd,
    output tcce_pkg::cur_stat_t stat
);

    localparam int CW2 = tcce_pkg::COL_W + 2;

    logic [tcce_pkg::ROW_W-1:0] row_reg, row_next;
    logic [tcce_pkg::COL_W-1:0] col_reg, col_next;

    logic [tcce_pkg::ROW_IDX_W-1:0] row_idx;
    tcce_pkg::phase_t               phase_sum;
    tcce_pkg::phase_t               phase;
    tcce_pkg::phase_t               step;
    logic [CW2-1:0]                 col_sum;
    logic [tcce_pkg::ROW_W-1:0]     row_dec;

    assign row_idx = row_reg[tcce_pkg::ROW_IDX_W-1:0];

    // Linear cell index mod TAB_WIDTH, from the two phase tables
    always_comb
    begin
        phase_sum = tcce_pkg::ROW_PHASE[row_idx] + tcce_pkg::COL_PHASE[col_reg];
        if (phase_sum >= tcce_pkg::PH_W'(tcce_pkg::TAB_WIDTH))
        begin
            phase = phase_sum - tcce_pkg::PH_W'(tcce_pkg::TAB_WIDTH);
        end
        else
        begin
            phase = phase_sum;
        end
        step    = tcce_pkg::PH_W'(tcce_pkg::TAB_WIDTH) - phase;
        col_sum = CW2'(col_reg) + CW2'(step);
        row_dec = row_reg - tcce_pkg::ROW_W'(1);
    end

    // Next cursor position
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.scroll)
        begin
            // Up one row; clamp to last cell if a tab overshot further
            if (row_dec >= tcce_pkg::ROW_W'(tcce_pkg::ROWS))
            begin
                row_next = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
                col_next = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
            end
            else
            begin
                row_next = row_dec;
            end
        end
        else if (cmd.move)
        begin
            unique case (cmd.code)
                tcce_pkg::CH_NUL:
                begin
                    row_next = row_reg;
                end
                tcce_pkg::CH_LF:
                begin
                    row_next = row_reg + tcce_pkg::ROW_W'(1);
                    col_next = '0;
                end
                tcce_pkg::CH_CR:
                begin
                    col_next = '0;
                end
                tcce_pkg::CH_BS:
                begin
                    // Held at cell zero; wraps back to the previous row end
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - tcce_pkg::COL_W'(1);
                    end
                    else if (row_reg != '0)
                    begin
                        row_next = row_dec;
                        col_next = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
                    end
                end
                tcce_pkg::CH_TAB:
                begin
                    // Tab step can cross at most one row boundary
                    if (col_sum >= CW2'(2 * tcce_pkg::COLUMNS))
                    begin
                        row_next = row_reg + tcce_pkg::ROW_W'(2);
                        col_next = tcce_pkg::COL_W'(col_sum - CW2'(2 * tcce_pkg::COLUMNS));
                    end
                    else if (col_sum >= CW2'(tcce_pkg::COLUMNS))
                    begin
                        row_next = row_reg + tcce_pkg::ROW_W'(1);
                        col_next = tcce_pkg::COL_W'(col_sum - CW2'(tcce_pkg::COLUMNS));
                    end
                    else
                    begin
                        col_next = tcce_pkg::COL_W'(col_sum);
                    end
                end
                default:
                begin
                    // Printable: advance one cell
                    if (col_reg == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1))
                    begin
                        row_next = row_reg + tcce_pkg::ROW_W'(1);
                        col_next = '0;
                    end
                    else
                    begin
                        col_next = col_reg + tcce_pkg::COL_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Status: linear index and past-last-row flag
    assign stat.pos  = tcce_pkg::CELL_W'(32'(row_idx) * tcce_pkg::COLUMNS)
                     + tcce_pkg::CELL_W'(col_reg);
    assign stat.over = (row_reg >= tcce_pkg::ROW_W'(tcce_pkg::ROWS));

endmodule

// File: verif/tcce_checker.sv
// Checker for the text console character engine: follows every accepted transfer,
// keeps its own screen, cursor and attribute, and compares each result strobe.
// Depends on tcce_pkg; instantiated beside the block by tb_text_console_character_engine.
module tcce_checker
    import tcce_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                opcode,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [ADDR_W-1:0]   read_address,
    input  logic                cfg_we,
    input  logic [ATTR_W-1:0]   cfg_wdata,
    input  logic                done,
    input  logic [CELL_DW-1:0]  read_data,
    input  logic [ADDR_W-1:0]   cursor_position,
    input  logic                scrolled,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CELL_DW-1:0] cell_word;
        logic [ADDR_W-1:0]  cursor;
        logic               scroll;
    } console_outcome_t;

    // Shadow of the console state
    logic [CELL_DW-1:0] console_screen [CELLS];
    int unsigned        console_cursor;
    logic [ATTR_W-1:0]  console_attr;

    console_outcome_t   outcome_q [$];
    console_outcome_t   want;
    int                 mismatches;

    // Applies one transfer to the shadow state and returns the result it should give
    function automatic console_outcome_t apply_console_item(
        input logic              op,
        input logic [CHAR_W-1:0] ch,
        input logic [ADDR_W-1:0] addr
    );
        console_outcome_t res;
        res = '0;
        if (op == OP_READ)
        begin
            if (addr < CELLS)
                res.cell_word = console_screen[addr];
        end
        else
        begin
            case (ch)
                CH_NUL: ;
                CH_LF:  console_cursor = (console_cursor / COLUMNS + 1) * COLUMNS;
                CH_CR:  console_cursor = (console_cursor / COLUMNS) * COLUMNS;
                CH_BS:
                begin
                    if (console_cursor > 0)
                        console_cursor = console_cursor - 1;
                end
                CH_TAB: console_cursor = (console_cursor / TAB_WIDTH + 1) * TAB_WIDTH;
                default:
                begin
                    console_screen[console_cursor] = {console_attr, ch};
                    console_cursor = console_cursor + 1;
                end
            endcase
            // past the last cell: move everything up a row, blank the bottom row
            if (console_cursor >= CELLS)
            begin
                for (int i = 0; i < CELLS - COLUMNS; i++)
                    console_screen[i] = console_screen[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++)
                    console_screen[i] = {console_attr, 8'h00};
                console_cursor = console_cursor - COLUMNS;
                if (console_cursor >= CELLS)
                    console_cursor = CELLS - 1;
                res.scroll = 1'b1;
            end
        end
        res.cursor = ADDR_W'(console_cursor);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            console_attr   = RESET_ATTR;
            console_cursor = 0;
            for (int i = 0; i < CELLS; i++)
                console_screen[i] = RESET_BLANK;
            outcome_q.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // result strobe against the oldest outstanding transfer
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h %0d %0b",
                             $time, read_data, cursor_position, scrolled);
                    mismatches++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (read_data !== want.cell_word)
                    begin
                        $display("%0t: read_data mismatch: expected %h, actual %h",
                                 $time, want.cell_word, read_data);
                        mismatches++;
                    end
                    if (cursor_position !== want.cursor)
                    begin
                        $display("%0t: cursor_position mismatch: expected %0d, actual %0d",
                                 $time, want.cursor, cursor_position);
                        mismatches++;
                    end
                    if (scrolled !== want.scroll)
                    begin
                        $display("%0t: scrolled mismatch: expected %0b, actual %0b",
                                 $time, want.scroll, scrolled);
                        mismatches++;
                    end
                end
            end

            if (cfg_we)
                console_attr = cfg_wdata;

            if (start && !busy)
                outcome_q.push_back(apply_console_item(opcode, char_code, read_address));

            fail_count <= mismatches;
            pending    <= outcome_q.size();
        end
    end

endmodule

// File: verif/tb_text_console_character_engine.sv
// Testbench top for the text console character engine: reset, directed and random
// transfers with attribute changes between phases, watchdog and verdict.
// Depends on tcce_pkg, text_console_character_engine and tcce_checker.
module tb_text_console_character_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    // longest quiet stretch: clearing pass or scroll plus a gap, with margin
    localparam int WATCHDOG_LIMIT = 20000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                opcode       = OP_PUT;
    logic [CHAR_W-1:0]   char_code    = '0;
    logic [ADDR_W-1:0]   read_address = '0;
    logic                cfg_we       = 1'b0;
    logic [ATTR_W-1:0]   cfg_wdata    = '0;
    logic                busy;
    logic                done;
    logic [CELL_DW-1:0]  read_data;
    logic [ADDR_W-1:0]   cursor_position;
    logic                scrolled;

    int                  fail_count;
    int                  pending;
    int                  quiet_cycles = 0;
    bit                  gaps_on      = 1'b0;

    always #5 clk = ~clk;

    text_console_character_engine u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .char_code       (char_code),
        .read_address    (read_address),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .read_data       (read_data),
        .cursor_position (cursor_position),
        .scrolled        (scrolled)
    );

    tcce_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .char_code       (char_code),
        .read_address    (read_address),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .read_data       (read_data),
        .cursor_position (cursor_position),
        .scrolled        (scrolled),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // Watchdog: cycles with neither a transfer nor a result
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("text_console_character_engine regression: fail");
            $finish;
        end
    end

    // One transfer, with an optional idle burst in front of it
    task automatic send_transfer(
        input logic              op,
        input logic [CHAR_W-1:0] ch,
        input logic [ADDR_W-1:0] addr
    );
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        char_code    <= ch;
        read_address <= addr;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_transfer(OP_PUT, ch, ADDR_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [ADDR_W-1:0] addr);
        send_transfer(OP_READ, CHAR_W'($urandom), addr);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Any byte that is not a control, mostly plain ASCII
    function automatic logic [CHAR_W-1:0] pick_text_char();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 4) != 0) begin
            c = CHAR_W'($urandom_range(8'h20, 8'h7e));
        end
        else begin
            c = CHAR_W'($urandom);
            while (c == CH_NUL || c == CH_BS || c == CH_TAB || c == CH_LF || c == CH_CR)
                c = CHAR_W'($urandom);
        end
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_read_address();
        if ($urandom_range(0, 7) == 0)
            return ADDR_W'($urandom_range(CELLS, 2047));
        return ADDR_W'($urandom_range(0, CELLS - 1));
    endfunction

    // Random phase: runs of text, line feeds, tabs, backspaces, reads and noise
    task automatic run_phase(input int target, input bit allow_gaps);
        int                sent;
        int                kind;
        int                len;
        logic              op;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < target) begin
            gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 99);
            len     = 0;
            if (kind < 35) begin
                len = $urandom_range(1, 40);
                repeat (len) put_char(pick_text_char());
            end
            else if (kind < 48) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 25)
                                                  : $urandom_range(1, 4);
                repeat (len) put_char(CH_LF);
            end
            else if (kind < 58) begin
                len = $urandom_range(1, 12);
                repeat (len) put_char(CH_TAB);
            end
            else if (kind < 66) begin
                len = $urandom_range(1, 10);
                repeat (len) put_char(CH_BS);
            end
            else if (kind < 70) begin
                len = 1;
                put_char(CH_CR);
            end
            else if (kind < 72) begin
                // ignored by the block, not counted
                put_char(CH_NUL);
            end
            else if (kind < 90) begin
                len = $urandom_range(1, 6);
                repeat (len) read_cell(pick_read_address());
            end
            else begin
                repeat ($urandom_range(1, 5)) begin
                    op = logic'($urandom_range(0, 1));
                    ch = CHAR_W'($urandom);
                    send_transfer(op, ch, ADDR_W'($urandom_range(0, 2047)));
                    if (op == OP_READ || ch != CH_NUL)
                        len++;
                end
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // wait out the clearing pass
        repeat (2) @(posedge clk);
        while (busy) @(posedge clk);

        // Directed: reset blanks, read limits, every control, byte extremes
        gaps_on = 1'b0;
        read_cell(ADDR_W'(0));
        read_cell(ADDR_W'(CELLS - 1));
        read_cell(ADDR_W'(CELLS));
        read_cell(ADDR_W'(2047));
        put_char(CH_BS);
        put_char(CH_NUL);
        put_char(8'h01);
        put_char(8'hff);
        put_char(8'h80);
        put_char(8'h7f);
        put_char(CH_TAB);
        put_char(8'h41);
        put_char(CH_CR);
        put_char(CH_LF);
        put_char(CH_BS);
        put_char(8'h0c);
        put_char(CH_TAB);
        read_cell(ADDR_W'(0));
        read_cell(ADDR_W'(3));
        read_cell(ADDR_W'(79));
        settle();
        write_attribute(8'hff);
        put_char(8'h5a);
        read_cell(ADDR_W'(88));
        settle();
        write_attribute(8'h00);
        put_char(8'h20);
        read_cell(ADDR_W'(89));
        settle();

        // Random phases, each under its own attribute
        write_attribute(ATTR_W'($urandom));
        run_phase(130, 1'b1);
        settle();
        write_attribute(8'hff);
        run_phase(130, 1'b1);
        settle();
        write_attribute(8'h00);
        run_phase(130, 1'b1);
        settle();
        write_attribute(ATTR_W'($urandom));
        run_phase(130, 1'b1);
        settle();
        // last part without idling
        write_attribute(RESET_ATTR);
        run_phase(130, 1'b0);
        settle();

        if (fail_count == 0)
            $display("text_console_character_engine regression: pass");
        else
            $display("text_console_character_engine regression: fail");
        $finish;
    end

endmodule
